// ===== rtl/lbpc_pkg.sv =====
package lbpc_pkg;

	localparam int FMT_W      = 2;
	localparam int DIM_W      = 13;
	localparam int ENT_W      = 9;
	localparam int ROW_W      = 12;
	localparam int HELD_W     = 24;
	localparam int MAX_HEIGHT = 4096;

	localparam logic [FMT_W-1:0] FMT_PALETTE = 2'd0;
	localparam logic [FMT_W-1:0] FMT_RGB565  = 2'd1;
	localparam logic [FMT_W-1:0] FMT_ARGB    = 2'd2;
	localparam logic [FMT_W-1:0] FMT_UNUSED  = 2'd3;

	localparam logic [FMT_W-1:0] RST_FORMAT  = FMT_PALETTE;
	localparam logic [DIM_W-1:0] RST_WIDTH   = 13'd1;
	localparam logic [DIM_W-1:0] RST_HEIGHT  = 13'd1;
	localparam logic [ENT_W-1:0] RST_ENTRIES = 9'd256;

	localparam logic [2:0] DIV_LAST = 3'd7;

	typedef enum logic [1:0] {
		REG_FORMAT  = 2'd0,
		REG_WIDTH   = 2'd1,
		REG_HEIGHT  = 2'd2,
		REG_ENTRIES = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_PALETTE = 2'd0,
		PH_PIXELS  = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WORK = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		JOB_PAL  = 2'd0,
		JOB_565  = 2'd1,
		JOB_ARGB = 2'd2
	} job_t;

	typedef struct packed {
		logic [FMT_W-1:0] fmt;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [ENT_W-1:0] entries;
	} cfg_t;

endpackage

// ===== rtl/lbpc_ram.sv =====
module lbpc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lbpc_regs.sv =====
module lbpc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output lbpc_pkg::cfg_t      cfg
);

	lbpc_pkg::cfg_t     cfg_q;
	lbpc_pkg::reg_idx_t idx;
	logic               wr;

	assign idx    = lbpc_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt     <= lbpc_pkg::RST_FORMAT;
			cfg_q.width   <= lbpc_pkg::RST_WIDTH;
			cfg_q.height  <= lbpc_pkg::RST_HEIGHT;
			cfg_q.entries <= lbpc_pkg::RST_ENTRIES;
		end else if (wr) begin
			unique case (idx)
				lbpc_pkg::REG_FORMAT:  cfg_q.fmt     <= pwdata[lbpc_pkg::FMT_W-1:0];
				lbpc_pkg::REG_WIDTH:   cfg_q.width   <= pwdata[lbpc_pkg::DIM_W-1:0];
				lbpc_pkg::REG_HEIGHT:  cfg_q.height  <= pwdata[lbpc_pkg::DIM_W-1:0];
				lbpc_pkg::REG_ENTRIES: cfg_q.entries <= pwdata[lbpc_pkg::ENT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lbpc_pkg::REG_FORMAT:  prdata = 32'(cfg_q.fmt);
			lbpc_pkg::REG_WIDTH:   prdata = 32'(cfg_q.width);
			lbpc_pkg::REG_HEIGHT:  prdata = 32'(cfg_q.height);
			lbpc_pkg::REG_ENTRIES: prdata = 32'(cfg_q.entries);
		endcase
	end

endmodule

// ===== rtl/lbpc_udiv.sv =====
// floor(chan*255/alpha), saturated at 255, chan passed through when alpha is 0; one quotient bit a cycle
module lbpc_udiv (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] chan,
	input  logic [7:0] alpha,
	output logic       busy,
	output logic [7:0] quot
);

	logic        busy_q;
	logic [2:0]  cnt_q;
	logic [7:0]  rem_q;
	logic [7:0]  low_q;
	logic [7:0]  a_q;
	logic [7:0]  quot_q;
	logic [15:0] prod;
	logic [8:0]  trial;
	logic [8:0]  diff;
	logic        ge;

	assign prod  = {chan, 8'h00} - {8'h00, chan};
	assign trial = {rem_q, low_q[7]};
	assign ge    = trial >= {1'b0, a_q};
	assign diff  = trial - {1'b0, a_q};
	assign busy  = busy_q;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (alpha != 8'h00) && (chan < alpha);
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == lbpc_pkg::DIV_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= alpha;
			rem_q <= prod[15:8];
			low_q <= prod[7:0];
			if (alpha == 8'h00) begin
				quot_q <= chan;
			end else if (chan >= alpha) begin
				quot_q <= 8'hFF;
			end else begin
				quot_q <= 8'h00;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? diff[7:0] : trial[7:0];
			low_q  <= {low_q[6:0], 1'b0};
			quot_q <= {quot_q[6:0], ge};
		end
	end

endmodule

// ===== rtl/lossless_bitmap_pixel_converter.sv =====
// channel  dir  fields (lsb first)
// s_*      in   tdata: data_byte[7:0]   tuser: first_byte
// m_*      out  tdata: red, green, blue, alpha   tuser: row_end   tlast: image_end
// apb      in   0x0 pixel_format, 0x4 image_width, 0x8 image_height, 0xC palette_entries
//
// A byte that gives no pixel is taken with no work state. A palette or 565 pixel byte adds
// a work state, which covers the palette RAM read. An ARGB pixel byte stays in its work state
// while the three color dividers run in parallel; each retires one quotient bit a cycle.
// Reset clears counters and config; palette RAM is not cleared and holds garbage until
// loaded. A finished pixel sits in the output register; while it is not taken the next
// pixel waits in its work state and s_tready stays low.
module lossless_bitmap_pixel_converter #(
	parameter int MAX_WIDTH     = 4096,
	parameter int PALETTE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [0:0]  s_tuser,   // first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red, green, blue, alpha
	output logic [0:0]  m_tuser,   // row_end
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW  = $clog2(PALETTE_DEPTH);
	localparam int EW  = $clog2(PALETTE_DEPTH + 1);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RBW = $clog2(4 * MAX_WIDTH + 1);
	localparam int RW  = lbpc_pkg::ROW_W;
	localparam int DW  = lbpc_pkg::DIM_W;
	localparam int HW  = lbpc_pkg::HELD_W;

	lbpc_pkg::cfg_t cfg;

	lbpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// clamped config
	logic [lbpc_pkg::ENT_W-1:0] ent_clamp;
	logic [EW-1:0]              ent_lim;
	logic [DW:0]                w_clamp;
	logic [WW-1:0]              w_lim;
	logic [DW-1:0]              h_lim;
	logic [1:0]                 bpp_sh;
	logic [1:0]                 bpp_m1;
	logic [RBW-1:0]             rowbytes;
	logic [RBW-1:0]             rb_p3;
	logic [RBW-1:0]             pitch;

	always_comb begin
		if (cfg.entries == '0) begin
			ent_clamp = lbpc_pkg::ENT_W'(1);
		end else if (cfg.entries > lbpc_pkg::ENT_W'(PALETTE_DEPTH)) begin
			ent_clamp = lbpc_pkg::ENT_W'(PALETTE_DEPTH);
		end else begin
			ent_clamp = cfg.entries;
		end

		if (cfg.width == '0) begin
			w_clamp = (DW+1)'(1);
		end else if ({1'b0, cfg.width} > (DW+1)'(MAX_WIDTH)) begin
			w_clamp = (DW+1)'(MAX_WIDTH);
		end else begin
			w_clamp = {1'b0, cfg.width};
		end

		if (cfg.height == '0) begin
			h_lim = DW'(1);
		end else if (cfg.height > DW'(lbpc_pkg::MAX_HEIGHT)) begin
			h_lim = DW'(lbpc_pkg::MAX_HEIGHT);
		end else begin
			h_lim = cfg.height;
		end

		priority if (cfg.fmt == lbpc_pkg::FMT_PALETTE) begin
			bpp_sh = 2'd0;
			bpp_m1 = 2'd0;
		end else if (cfg.fmt == lbpc_pkg::FMT_RGB565) begin
			bpp_sh = 2'd1;
			bpp_m1 = 2'd1;
		end else begin
			bpp_sh = 2'd2;
			bpp_m1 = 2'd3;
		end
	end

	assign ent_lim  = ent_clamp[EW-1:0];
	assign w_lim    = w_clamp[WW-1:0];
	assign rowbytes = RBW'(w_lim) << bpp_sh;
	assign rb_p3    = rowbytes + RBW'(3);
	assign pitch    = {rb_p3[RBW-1:2], 2'b00};

	// stream position state
	lbpc_pkg::phase_t phase_q, ph_e, phase_d;
	logic [1:0]       bip_q, bip_e, bip_d;
	logic [EW-1:0]    ent_q, ent_e, ent_d;
	logic [HW-1:0]    held_q, held_e, held_d, held_sh;
	logic [RBW-1:0]   pos_q, pos_e, pos_d;
	logic [RBW:0]     pos_p1;
	logic [RW-1:0]    row_q, row_e, row_d;
	logic             row_last;
	logic             first;
	logic             acc;
	logic             emit;
	logic             row_end;
	logic             img_end;
	logic             pal_we;

	assign first = s_tuser[0];
	assign acc   = s_tvalid & s_tready;

	always_comb begin
		if (first) begin
			ph_e   = (cfg.fmt == lbpc_pkg::FMT_PALETTE) ? lbpc_pkg::PH_PALETTE
			                                             : lbpc_pkg::PH_PIXELS;
			bip_e  = '0;
			ent_e  = '0;
			held_e = '0;
			pos_e  = '0;
			row_e  = '0;
		end else begin
			ph_e   = phase_q;
			bip_e  = bip_q;
			ent_e  = ent_q;
			held_e = held_q;
			pos_e  = pos_q;
			row_e  = row_q;
		end
	end

	assign held_sh  = {held_e[HW-9:0], s_tdata};
	assign pos_p1   = {1'b0, pos_e} + (RBW+1)'(1);
	assign row_last = ({1'b0, row_e} + DW'(1)) >= h_lim;

	always_comb begin
		phase_d = ph_e;
		bip_d   = bip_e;
		ent_d   = ent_e;
		held_d  = held_e;
		pos_d   = pos_e;
		row_d   = row_e;
		emit    = 1'b0;
		row_end = 1'b0;
		img_end = 1'b0;
		pal_we  = 1'b0;
		unique case (ph_e)
			lbpc_pkg::PH_PALETTE: begin
				if (bip_e >= 2'd2) begin
					pal_we = 1'b1;
					bip_d  = '0;
					ent_d  = ent_e + EW'(1);
				end else begin
					bip_d = bip_e + 2'd1;
				end
				held_d = held_sh;
				if (ent_d >= ent_lim) begin
					phase_d = lbpc_pkg::PH_PIXELS;
					bip_d   = '0;
					held_d  = '0;
				end
			end
			lbpc_pkg::PH_PIXELS: begin
				if (cfg.fmt != lbpc_pkg::FMT_UNUSED) begin
					if (pos_e < rowbytes) begin
						if (bip_e >= bpp_m1) begin
							emit    = 1'b1;
							row_end = pos_p1 >= {1'b0, rowbytes};
							img_end = row_end && row_last;
							bip_d   = '0;
						end else begin
							bip_d = bip_e + 2'd1;
						end
						held_d = held_sh;
					end
					if (pos_p1 >= {1'b0, pitch}) begin
						pos_d = '0;
						bip_d = '0;
						if (row_last) begin
							phase_d = lbpc_pkg::PH_DONE;
						end else begin
							row_d = row_e + RW'(1);
						end
					end else begin
						pos_d = pos_p1[RBW-1:0];
					end
				end
			end
			lbpc_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lbpc_pkg::PH_PALETTE;
			bip_q   <= '0;
			ent_q   <= '0;
			held_q  <= '0;
			pos_q   <= '0;
			row_q   <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			bip_q   <= bip_d;
			ent_q   <= ent_d;
			held_q  <= held_d;
			pos_q   <= pos_d;
			row_q   <= row_d;
		end
	end

	// palette memory
	logic [HW-1:0] pal_rdata;
	logic          pal_re;

	assign pal_re = acc & emit & (cfg.fmt == lbpc_pkg::FMT_PALETTE);

	lbpc_ram #(
		.WIDTH (HW),
		.DEPTH (PALETTE_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (acc & pal_we),
		.waddr (ent_e[AW-1:0]),
		.wdata (held_sh),
		.re    (pal_re),
		.raddr (AW'(s_tdata) & AW'(PALETTE_DEPTH - 1)),
		.rdata (pal_rdata)
	);

	// un-premultiply
	logic       div_go;
	logic [2:0] div_busy;
	logic [7:0] div_r, div_g, div_b;

	assign div_go = acc & emit & (cfg.fmt == lbpc_pkg::FMT_ARGB);

	lbpc_udiv u_div_r (
		.clk (clk), .arst_n (arst_n), .start (div_go),
		.chan (held_e[15:8]), .alpha (held_e[23:16]), .busy (div_busy[0]), .quot (div_r)
	);

	lbpc_udiv u_div_g (
		.clk (clk), .arst_n (arst_n), .start (div_go),
		.chan (held_e[7:0]), .alpha (held_e[23:16]), .busy (div_busy[1]), .quot (div_g)
	);

	lbpc_udiv u_div_b (
		.clk (clk), .arst_n (arst_n), .start (div_go),
		.chan (s_tdata), .alpha (held_e[23:16]), .busy (div_busy[2]), .quot (div_b)
	);

	// pixel job
	lbpc_pkg::job_t kind_s1;
	logic [HW-1:0]  col_s1;
	logic [7:0]     alpha_s1;
	logic           hit_s1;
	logic           row_end_s1;
	logic           img_end_s1;

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			priority if (cfg.fmt == lbpc_pkg::FMT_PALETTE) begin
				kind_s1 <= lbpc_pkg::JOB_PAL;
			end else if (cfg.fmt == lbpc_pkg::FMT_RGB565) begin
				kind_s1 <= lbpc_pkg::JOB_565;
			end else begin
				kind_s1 <= lbpc_pkg::JOB_ARGB;
			end
			col_s1     <= {s_tdata[7:3], 3'b000,
			               s_tdata[2:0], held_e[7:5], 2'b00,
			               held_e[4:0], 3'b000};
			alpha_s1   <= (cfg.fmt == lbpc_pkg::FMT_ARGB) ? held_e[23:16] : 8'hFF;
			hit_s1     <= {1'b0, s_tdata} < ent_clamp;
			row_end_s1 <= row_end;
			img_end_s1 <= img_end;
		end
	end

	logic [HW-1:0] res_rgb;
	logic          res_ready;

	always_comb begin
		unique case (kind_s1)
			lbpc_pkg::JOB_PAL: begin
				res_rgb   = hit_s1 ? pal_rdata : '0;
				res_ready = 1'b1;
			end
			lbpc_pkg::JOB_565: begin
				res_rgb   = col_s1;
				res_ready = 1'b1;
			end
			lbpc_pkg::JOB_ARGB: begin
				res_rgb   = {div_r, div_g, div_b};
				res_ready = (div_busy == '0);
			end
			default: begin
				res_rgb   = '0;
				res_ready = 1'b1;
			end
		endcase
	end

	// control
	lbpc_pkg::state_t state_q, state_d;
	logic             out_free;
	logic             out_load;
	logic             out_valid_q;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbpc_pkg::ST_IDLE: begin
				if (acc && emit) begin
					state_d = lbpc_pkg::ST_WORK;
				end
			end
			lbpc_pkg::ST_WORK: begin
				if (res_ready && out_free) begin
					state_d = lbpc_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		s_tready = (state_q == lbpc_pkg::ST_IDLE);
		out_load = (state_q == lbpc_pkg::ST_WORK) && res_ready && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbpc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	logic [31:0] out_data_q;
	logic        out_row_q;
	logic        out_img_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {alpha_s1, res_rgb[7:0], res_rgb[15:8], res_rgb[23:16]};
			out_row_q  <= row_end_s1;
			out_img_q  <= img_end_s1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_row_q;
	assign m_tlast    = out_img_q;

endmodule

// ===== tb/lossless_bitmap_pixel_converter_tb.sv =====
`timescale 1ns / 100ps

module lossless_bitmap_pixel_converter_tb;
	import lbpc_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 32;
	localparam int RANDOM_WORDS = 560;

	typedef struct {
		bit [7:0] red;
		bit [7:0] green;
		bit [7:0] blue;
		bit [7:0] alpha;
		bit       row_end;
		bit       image_end;
	} rgba_t;

	// RGBA predictor plus pixel scoreboard
	class rgba_predictor;
		bit [1:0]  fmt;
		bit [12:0] width;
		bit [12:0] height;
		bit [8:0]  entries;

		bit [23:0] pal_ram[256];
		bit        pal_valid[256];
		phase_t    stage;
		bit [9:0]  pal_bytes;
		bit [14:0] row_byte;
		bit [11:0] row_idx;
		bit [1:0]  pix_byte;
		bit [23:0] shift_reg;

		rgba_t pending_pixels[$];
		int    errors;
		int    checked;

		function new();
			fmt     = RST_FORMAT;
			width   = RST_WIDTH;
			height  = RST_HEIGHT;
			entries = RST_ENTRIES;
			errors  = 0;
			checked = 0;
			foreach (pal_valid[i]) pal_valid[i] = 1'b0;
			restart();
		endfunction

		function void restart();
			stage     = (fmt == FMT_PALETTE) ? PH_PALETTE : PH_PIXELS;
			pal_bytes = '0;
			row_byte  = '0;
			row_idx   = '0;
			pix_byte  = '0;
			shift_reg = '0;
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function bit [7:0] unpremul(bit [7:0] c, bit [7:0] a);
			int unsigned q;
			if (a == 0)
				return c;
			q = (32'(c) * 255) / a;
			return q > 255 ? 8'hFF : q[7:0];
		endfunction

		function void set_reg(reg_idx_t idx, bit [31:0] v);
			case (idx)
				REG_FORMAT:  fmt     = v[1:0];
				REG_WIDTH:   width   = v[12:0];
				REG_HEIGHT:  height  = v[12:0];
				REG_ENTRIES: entries = v[8:0];
			endcase
		endfunction

		// keeps palette reads on entries that were loaded; 0 = nothing safe to send
		function bit safe_index(inout bit [7:0] b);
			int unsigned ent;
			bit [7:0]    probe;
			ent = clamp(entries, 1, 256);
			if (b >= ent || pal_valid[b])
				return 1'b1;
			if (ent < 256) begin
				b = 8'($urandom_range(ent, 255));
				return 1'b1;
			end
			probe = 8'($urandom_range(0, 255));
			for (int i = 0; i < 256; i++) begin
				if (pal_valid[probe]) begin
					b = probe;
					return 1'b1;
				end
				probe = probe + 1'b1;
			end
			return 1'b0;
		endfunction

		function void take_byte(bit [7:0] b, bit first_b);
			int unsigned ent, w, h, bpp, rowbytes, pitch, pos, slot;
			rgba_t       px;
			bit          emit;
			bit [15:0]   word565;
			ent  = clamp(entries, 1, 256);
			w    = clamp(width, 1, 4096);
			h    = clamp(height, 1, MAX_HEIGHT);
			emit = 1'b0;
			if (first_b)
				restart();
			if (stage == PH_PALETTE) begin
				if (pix_byte >= 2) begin
					slot = pal_bytes / 3;
					if (slot < 256) begin
						pal_ram[slot]   = {shift_reg[15:0], b};
						pal_valid[slot] = 1'b1;
					end
					pix_byte = '0;
				end else begin
					pix_byte = pix_byte + 1'b1;
				end
				shift_reg = {shift_reg[15:0], b};
				pal_bytes = pal_bytes + 1'b1;
				if (32'(pal_bytes) >= 3 * ent) begin
					stage     = PH_PIXELS;
					pix_byte  = '0;
					shift_reg = '0;
				end
				return;
			end
			if (stage != PH_PIXELS || fmt == FMT_UNUSED)
				return;

			bpp      = (fmt == FMT_PALETTE) ? 1 : (fmt == FMT_RGB565 ? 2 : 4);
			rowbytes = w * bpp;
			pitch    = (rowbytes + 3) & ~32'd3;
			pos      = row_byte;

			if (pos < rowbytes) begin
				if (32'(pix_byte) + 1 >= bpp) begin
					px = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'hFF,
						row_end: 1'b0, image_end: 1'b0};
					case (fmt)
						FMT_PALETTE: begin
							if (b < ent)
								{px.red, px.green, px.blue} = pal_ram[b];
						end
						FMT_RGB565: begin
							word565  = {b, shift_reg[7:0]};
							px.red   = {word565[15:11], 3'b000};
							px.green = {word565[10:5], 2'b00};
							px.blue  = {word565[4:0], 3'b000};
						end
						default: begin
							px.alpha = shift_reg[23:16];
							px.red   = unpremul(shift_reg[15:8], px.alpha);
							px.green = unpremul(shift_reg[7:0], px.alpha);
							px.blue  = unpremul(b, px.alpha);
						end
					endcase
					emit         = 1'b1;
					px.row_end   = (pos + 1 >= rowbytes);
					px.image_end = px.row_end && (32'(row_idx) + 1 >= h);
					pix_byte     = '0;
				end else begin
					pix_byte = pix_byte + 1'b1;
				end
				shift_reg = {shift_reg[15:0], b};
			end

			if (pos + 1 >= pitch) begin
				row_byte = '0;
				pix_byte = '0;
				if (32'(row_idx) + 1 >= h)
					stage = PH_DONE;
				else
					row_idx = row_idx + 1'b1;
			end else begin
				row_byte = row_byte + 1'b1;
			end

			if (emit)
				pending_pixels.push_back(px);
		endfunction

		task report_mismatch(input string what);
			errors++;
			if (errors <= 50)
				$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_pixel(input bit [31:0] data, input bit row_end, input bit image_end);
			rgba_t want;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel %08h arrived with none expected", data));
				return;
			end
			want = pending_pixels.pop_front();
			checked++;
			if (data[7:0] != want.red)
				report_mismatch($sformatf("pixel %0d red %02h want %02h",
					checked, data[7:0], want.red));
			if (data[15:8] != want.green)
				report_mismatch($sformatf("pixel %0d green %02h want %02h",
					checked, data[15:8], want.green));
			if (data[23:16] != want.blue)
				report_mismatch($sformatf("pixel %0d blue %02h want %02h",
					checked, data[23:16], want.blue));
			if (data[31:24] != want.alpha)
				report_mismatch($sformatf("pixel %0d alpha %02h want %02h",
					checked, data[31:24], want.alpha));
			if (row_end != want.row_end)
				report_mismatch($sformatf("pixel %0d row_end %0b want %0b",
					checked, row_end, want.row_end));
			if (image_end != want.image_end)
				report_mismatch($sformatf("pixel %0d image_end %0b want %0b",
					checked, image_end, want.image_end));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // data_byte
	logic [0:0]  s_tuser;   // first_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // red, green, blue, alpha
	logic [0:0]  m_tuser;   // row_end
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rgba_predictor sb = new();

	bit [7:0] img_bytes[$];
	int       bytes_sent  = 0;
	int       images_sent = 0;
	int       cycles      = 0;
	bit       no_idle     = 1'b0;
	bit       tx_gaps     = 1'b1;
	bit       rx_gaps     = 1'b1;
	int       hold_req    = 0;
	int       stall_left  = 0;
	int       rx_window   = 0;

	lossless_bitmap_pixel_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// pixel sink: check accepted words, then pick next tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_pixel(m_tdata, m_tuser[0], m_tlast);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_gaps && !no_idle && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			rx_window++;
			if (rx_window % 64 == 0)
				rx_gaps = !no_idle && $urandom_range(0, 2) != 0;
		end
	end

	task automatic push_byte(input bit [7:0] value, input bit first_b);
		bit [7:0] b;
		b = value;
		if (!first_b && sb.fmt == FMT_PALETTE && sb.stage == PH_PIXELS && !sb.safe_index(b))
			return;
		if (tx_gaps && !no_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first_b;
		do @(posedge clk); while (!s_tready);
		sb.take_byte(b, first_b);
		bytes_sent++;
		if (bytes_sent % 64 == 0)
			tx_gaps = $urandom_range(0, 2) != 0;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input bit [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic configure(input bit [1:0] fmt, input int unsigned w, h, ent);
		wait_drain();
		write_reg(REG_FORMAT, fmt);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_ENTRIES, ent);
	endtask

	task automatic send_img_bytes();
		foreach (img_bytes[i])
			push_byte(img_bytes[i], i == 0);
	endtask

	// well-formed stream with random content; cut >= 0 truncates it
	task automatic build_image(input bit [1:0] fmt, input int unsigned w, h, ent,
			input int cut);
		int unsigned bpp, rowbytes, pitch, rows;
		bit [7:0]    alpha_b;
		img_bytes.delete();
		if (fmt == FMT_UNUSED) begin
			repeat ($urandom_range(1, 10)) img_bytes.push_back(8'($urandom));
			return;
		end
		if (fmt == FMT_PALETTE)
			repeat (3 * ent) img_bytes.push_back(8'($urandom));
		bpp      = (fmt == FMT_PALETTE) ? 1 : (fmt == FMT_RGB565 ? 2 : 4);
		rowbytes = w * bpp;
		pitch    = (rowbytes + 3) & ~32'd3;
		rows     = h;
		if (cut >= 0 && rows > cut / pitch + 1)
			rows = cut / pitch + 1;
		repeat (rows) begin
			repeat (w) begin
				case (fmt)
					FMT_PALETTE: begin
						img_bytes.push_back($urandom_range(0, 3) != 0 ?
							8'($urandom_range(0, ent - 1)) : 8'($urandom));
					end
					FMT_RGB565: begin
						img_bytes.push_back(8'($urandom));
						img_bytes.push_back(8'($urandom));
					end
					default: begin
						case ($urandom_range(0, 3))
							0:       alpha_b = 8'h00;
							1:       alpha_b = 8'hFF;
							2:       alpha_b = 8'($urandom_range(1, 15));
							default: alpha_b = 8'($urandom);
						endcase
						img_bytes.push_back(alpha_b);
						repeat (3)
							img_bytes.push_back($urandom_range(0, 1) ?
								8'($urandom_range(0, alpha_b)) : 8'($urandom));
					end
				endcase
			end
			repeat (pitch - rowbytes) img_bytes.push_back(8'($urandom));
		end
		if (cut >= 0)
			while (img_bytes.size() > cut) void'(img_bytes.pop_back());
	endtask

	task automatic run_image(input bit [1:0] fmt, input int unsigned w, h, ent,
			input int cut);
		configure(fmt, w, h, ent);
		build_image(fmt, sb.clamp(w, 1, 4096), sb.clamp(h, 1, MAX_HEIGHT),
			sb.clamp(ent, 1, 256), cut);
		send_img_bytes();
		images_sent++;
		if (cut < 0 && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
	endtask

	function automatic int unsigned extreme_dim();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 4096;
			2:       return 8191;
			3:       return 1;
			default: return $urandom_range(2, 9);
		endcase
	endfunction

	function automatic int unsigned extreme_entries();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 256;
			2:       return 511;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	task automatic poke_registers();
		reg_idx_t    idx;
		bit [31:0]   v;
		wait_drain();
		repeat ($urandom_range(1, 2)) begin
			idx = reg_idx_t'($urandom_range(0, 3));
			case (idx)
				REG_FORMAT:  v = $urandom_range(0, 3);
				REG_ENTRIES: v = $urandom_range(0, 1) ? extreme_entries() : $urandom_range(0, 20);
				default:     v = $urandom_range(0, 1) ? extreme_dim() : $urandom_range(0, 20);
			endcase
			write_reg(idx, v);
		end
	endtask

	initial begin
		int start;
		int pick;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// palette: two entries, in-range and out-of-range indexes, one pad byte
		configure(FMT_PALETTE, 3, 1, 2);
		img_bytes = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFE, 8'h7F,
			8'h00, 8'h01, 8'hFF, 8'hAA};
		send_img_bytes();

		// 565 all ones / all zeros, then a stray byte after the image
		configure(FMT_RGB565, 2, 1, 2);
		img_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00};
		send_img_bytes();
		push_byte(8'h5A, 1'b0);

		// argb: zero alpha passes through, half alpha saturates the channel above it
		configure(FMT_ARGB, 2, 1, 2);
		img_bytes = '{8'h00, 8'h12, 8'h34, 8'h56, 8'h80, 8'hFF, 8'h00, 8'h7F};
		send_img_bytes();

		// unused format ignores data
		configure(FMT_UNUSED, 2, 1, 2);
		img_bytes = '{8'hC3};
		send_img_bytes();

		// sink holds off long enough to back the input up
		hold_req = 400;
		run_image(FMT_RGB565, 8, 4, 1, -1);

		// larger palette load, then the widest row cut short
		run_image(FMT_PALETTE, 2, 1, 64, -1);
		run_image(FMT_PALETTE, 4096, 1, 3, 60);

		start = bytes_sent;
		while (bytes_sent - start < RANDOM_WORDS) begin
			no_idle = (bytes_sent - start) > RANDOM_WORDS * 85 / 100;
			pick    = $urandom_range(0, 99);
			if (pick < 70) begin
				run_image(2'($urandom_range(0, 2)), $urandom_range(1, 9),
					$urandom_range(1, 3), $urandom_range(1, 12), -1);
			end else if (pick < 82) begin
				run_image(2'($urandom_range(0, 2)), extreme_dim(), extreme_dim(),
					extreme_entries(), $urandom_range(1, 40));
			end else if (pick < 90) begin
				run_image(2'($urandom_range(0, 2)), $urandom_range(1, 9),
					$urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 30));
				poke_registers();
				repeat ($urandom_range(5, 20)) push_byte(8'($urandom), 1'b0);
			end else if (pick < 95) begin
				run_image(FMT_UNUSED, $urandom_range(1, 9), $urandom_range(1, 3),
					$urandom_range(1, 12), -1);
			end else begin
				run_image(2'($urandom_range(0, 2)), 0, 0, 0, -1);
			end
		end

		wait_drain();
		$display("run: %0d words in, %0d pixels checked over %0d images",
			bytes_sent, sb.checked, images_sent);
		$display("formats palette/565/argb/unused, clamped and widest sizes, long sink stall");
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
